// ----- rtl/matrix4_transform_accumulator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 transform accumulator
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_TRANSFORM_ACCUMULATOR_DEFINES_SVH
`define MATRIX4_TRANSFORM_ACCUMULATOR_DEFINES_SVH

// next-cycle implication, off while reset is held
`define MXA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// condition that must hold in the cycle after reset
`define MXA_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mxa_pkg.sv -----
// ----------------------------------------------------------------------------
// mxa_pkg
// Types, codes and tables shared by the transform accumulator modules.
// ----------------------------------------------------------------------------
package mxa_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int MAT_DEPTH        = 16;
    localparam int MAT_AW           = 4;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic [3:0] REQ_IDENTITY  = 4'd0;
    localparam logic [3:0] REQ_ZERO      = 4'd1;
    localparam logic [3:0] REQ_LOAD      = 4'd2;
    localparam logic [3:0] REQ_TRANSLATE = 4'd3;
    localparam logic [3:0] REQ_SCALE     = 4'd4;
    localparam logic [3:0] REQ_ROT_AXIS  = 4'd5;
    localparam logic [3:0] REQ_ROT_X     = 4'd6;
    localparam logic [3:0] REQ_ROT_Y     = 4'd7;
    localparam logic [3:0] REQ_ROT_Z     = 4'd8;
    localparam logic [3:0] REQ_READ      = 4'd9;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] value;
    } sat_val_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } trig_res_t;

    function automatic sat_val_t sat36(input logic signed [35:0] v);
        sat_val_t r;
        if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
            r.sat   = 1'b0;
            r.value = v[31:0];
        end else begin
            r.sat   = 1'b1;
            r.value = v[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return r;
    endfunction

    // arctangent of 2^-i in Q8.24 degrees
    function automatic logic signed [32:0] atan_q24(input logic [4:0] i);
        logic signed [32:0] r;
        case (i)
            5'd0:    r = 33'sd754974720;
            5'd1:    r = 33'sd445687602;
            5'd2:    r = 33'sd235489089;
            5'd3:    r = 33'sd119537938;
            5'd4:    r = 33'sd60000934;
            5'd5:    r = 33'sd30029717;
            5'd6:    r = 33'sd15018523;
            5'd7:    r = 33'sd7509720;
            5'd8:    r = 33'sd3754917;
            5'd9:    r = 33'sd1877466;
            5'd10:   r = 33'sd938734;
            5'd11:   r = 33'sd469367;
            5'd12:   r = 33'sd234684;
            5'd13:   r = 33'sd117342;
            5'd14:   r = 33'sd58671;
            5'd15:   r = 33'sd29335;
            5'd16:   r = 33'sd14668;
            5'd17:   r = 33'sd7334;
            5'd18:   r = 33'sd3667;
            5'd19:   r = 33'sd1833;
            5'd20:   r = 33'sd917;
            5'd21:   r = 33'sd458;
            5'd22:   r = 33'sd229;
            5'd23:   r = 33'sd115;
            default: r = 33'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/mxa_mem.sv -----
// ----------------------------------------------------------------------------
// mxa_mem
// Matrix element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mxa_mem (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [mxa_pkg::MAT_AW-1:0] waddr,
    input  logic signed [31:0]         wdata,
    input  logic [mxa_pkg::MAT_AW-1:0] raddr,
    output logic signed [31:0]         rdata
);
    import mxa_pkg::*;

    logic signed [31:0] mem_reg [MAT_DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mxa_mul.sv -----
// ----------------------------------------------------------------------------
// mxa_mul
// Shared fixed-point multiplier: registered product, then round half up,
// shift and saturate to 32 bits.
// ----------------------------------------------------------------------------
module mxa_mul #(
    parameter int FRAC_BITS = mxa_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output mxa_pkg::sat_val_t  res
);
    import mxa_pkg::*;

    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;
    logic signed [63:0] shifted;

    assign prod_next = 64'(a) * 64'(b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    always_comb begin
        shifted = (prod_reg + RND) >>> FRAC_BITS;
        if ((&shifted[63:31]) || !(|shifted[63:31])) begin
            res.sat   = 1'b0;
            res.value = shifted[31:0];
        end else begin
            res.sat   = 1'b1;
            res.value = shifted[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

endmodule

// ----- rtl/mxa_trig.sv -----
// ----------------------------------------------------------------------------
// mxa_trig
// Cosine and sine of an angle in degrees: modulo-360 reduction by
// restoring subtraction, quadrant fold, then an iterative CORDIC.
// ----------------------------------------------------------------------------
module mxa_trig #(
    parameter int FRAC_BITS    = mxa_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mxa_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] angle,
    output mxa_pkg::trig_res_t res
);
    import mxa_pkg::*;

    localparam longint FULL_L    = longint'(360) <<< FRAC_BITS;
    localparam longint OFF_L     = FULL_L - ((longint'(1) <<< 31) % FULL_L);
    localparam int     RED_STEPS = 35 - $clog2(FULL_L);
    localparam int     NSTEPS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int     Z_SH      = 24 - FRAC_BITS;
    localparam int     OUT_SH    = 30 - FRAC_BITS;

    localparam logic [33:0]        OFF     = 34'(OFF_L);
    localparam logic [33:0]        D_INIT  = 34'(FULL_L <<< (RED_STEPS - 1));
    localparam logic signed [35:0] FULL_S  = 36'(FULL_L);
    localparam logic signed [35:0] HALF_S  = 36'(FULL_L / 2);
    localparam logic signed [35:0] QUART_S = 36'(FULL_L / 4);
    localparam logic signed [33:0] RND     = 34'sd1 <<< (29 - FRAC_BITS);

    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_RED  = 5'b00010,
        T_FOLD = 5'b00100,
        T_ROT  = 5'b01000,
        T_FIN  = 5'b10000
    } tstate_t;

    tstate_t            st_reg, st_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [33:0]        rem_reg, rem_next;
    logic [33:0]        d_reg, d_next;
    logic               neg_reg, neg_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [32:0] z_reg, z_next;
    logic               done_reg, done_next;
    logic signed [31:0] cos_reg, cos_next;
    logic signed [31:0] sin_reg, sin_next;

    logic signed [35:0] r;
    logic signed [33:0] dx, dy, xf, yf;
    logic signed [32:0] at;

    always_comb begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        done_next = 1'b0;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        r         = 36'(rem_reg);
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        at        = atan_q24(cnt_reg);
        xf        = neg_reg ? -x_reg : x_reg;
        yf        = neg_reg ? -y_reg : y_reg;

        case (st_reg)
            T_IDLE: begin
                if (start) begin
                    // angle + 2^31 as unsigned, offset so the modulus is unchanged
                    rem_next = {2'b00, ~angle[31], angle[30:0]} + OFF;
                    d_next   = D_INIT;
                    cnt_next = '0;
                    st_next  = T_RED;
                end
            end
            T_RED: begin
                if (rem_reg >= d_reg) begin
                    rem_next = rem_reg - d_reg;
                end
                d_next   = d_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(RED_STEPS - 1)) begin
                    st_next = T_FOLD;
                end
            end
            T_FOLD: begin
                if (r >= HALF_S) begin
                    r = r - FULL_S;
                end
                neg_next = 1'b0;
                if (r > QUART_S) begin
                    r        = r - HALF_S;
                    neg_next = 1'b1;
                end else if (r < -QUART_S) begin
                    r        = r + HALF_S;
                    neg_next = 1'b1;
                end
                z_next   = 33'(r <<< Z_SH);
                x_next   = CORDIC_GAIN_Q30;
                y_next   = '0;
                cnt_next = '0;
                st_next  = T_ROT;
            end
            T_ROT: begin
                if (!z_reg[32]) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(NSTEPS - 1)) begin
                    st_next = T_FIN;
                end
            end
            T_FIN: begin
                cos_next  = 32'((xf + RND) >>> OUT_SH);
                sin_next  = 32'((yf + RND) >>> OUT_SH);
                done_next = 1'b1;
                st_next   = T_IDLE;
            end
            default: begin
                st_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= T_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign res.done  = done_reg;
    assign res.cos_v = cos_reg;
    assign res.sin_v = sin_reg;

endmodule

// ----- rtl/matrix4_transform_accumulator.sv -----
// ----------------------------------------------------------------------------
// matrix4_transform_accumulator
// 4x4 fixed-point transform matrix held in a 16-entry memory; each item
// applies one operation and returns one element.
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_req_type s_elem_index s_load_value
//           |           | s_op_x s_op_y s_op_z s_angle_deg
//   m_      | out       | m_valid m_ready m_element_value m_saturated
//
// One item at a time. The time to a result is set by the single shared
// multiplier, one product per cycle, and, for rotations, by the iterative
// CORDIC. After reset a clearing pass writes the identity matrix into all
// 16 entries; s_ready stays low.
// A stalled result is held in the output register; s_ready returns as soon
// as the result is registered, the next result waits for that register.
// ----------------------------------------------------------------------------
module matrix4_transform_accumulator #(
    parameter int FRAC_BITS    = mxa_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mxa_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_req_type,
    input  logic [3:0]         s_elem_index,
    input  logic signed [31:0] s_load_value,
    input  logic signed [31:0] s_op_x,
    input  logic signed [31:0] s_op_y,
    input  logic signed [31:0] s_op_z,
    input  logic signed [31:0] s_angle_deg,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_element_value,
    output logic               m_saturated
);
    import mxa_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_CLEAR  = 10'b0000000010,
        ST_LOAD   = 10'b0000000100,
        ST_TRIG   = 10'b0000001000,
        ST_AXPRE  = 10'b0000010000,
        ST_COEF   = 10'b0000100000,
        ST_COLRD  = 10'b0001000000,
        ST_COLMAC = 10'b0010000000,
        ST_RDOUT  = 10'b0100000000,
        ST_FIN    = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         col_reg, col_next;
    logic               init_reg, init_next;
    logic [3:0]         req_reg, req_next;
    logic [3:0]         idx_reg, idx_next;
    logic signed [31:0] load_reg, load_next;
    logic signed [31:0] vx_reg, vx_next;
    logic signed [31:0] vy_reg, vy_next;
    logic signed [31:0] vz_reg, vz_next;
    logic signed [31:0] c_reg, c_next;
    logic signed [31:0] s_reg, s_next;
    logic signed [31:0] c1_reg, c1_next;
    logic signed [31:0] scr_reg [15];
    logic signed [31:0] scr_next [15];
    logic signed [31:0] coef_reg [3][4];
    logic signed [31:0] coef_next [3][4];
    logic               cneg_reg [3][4];
    logic               cneg_next [3][4];
    logic signed [31:0] mcol_reg [4];
    logic signed [31:0] mcol_next [4];
    logic               iss_vld_reg, iss_vld_next;
    logic               iss_ax_reg, iss_ax_next;
    logic               iss_neg_reg, iss_neg_next;
    logic [1:0]         iss_row_reg, iss_row_next;
    logic [1:0]         iss_term_reg, iss_term_next;
    logic [3:0]         iss_scr_reg, iss_scr_next;
    logic signed [35:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_value_reg, m_value_next;
    logic               m_sat_reg, m_sat_next;

    logic                       mem_we;
    logic [MAT_AW-1:0]          mem_waddr, mem_raddr;
    logic signed [31:0]         mem_wdata, mem_rdata;
    logic signed [31:0]         mul_a, mul_b;
    sat_val_t                   mul_res;
    logic                       trig_start;
    trig_res_t                  trig_res;
    logic                       accept;
    logic signed [35:0]         contrib, sum36;
    sat_val_t                   wsum;
    sat_val_t                   rv [9];

    mxa_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mxa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .res  (mul_res)
    );

    mxa_trig #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (s_angle_deg),
        .res     (trig_res)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // axis rotation coefficients from the precomputed products
    always_comb begin
        rv[0] = sat36(36'(scr_reg[9])  + 36'(c_reg));
        rv[1] = sat36(36'(scr_reg[12]) + 36'(scr_reg[8]));
        rv[2] = sat36(36'(scr_reg[13]) - 36'(scr_reg[7]));
        rv[3] = sat36(36'(scr_reg[12]) - 36'(scr_reg[8]));
        rv[4] = sat36(36'(scr_reg[10]) + 36'(c_reg));
        rv[5] = sat36(36'(scr_reg[14]) + 36'(scr_reg[6]));
        rv[6] = sat36(36'(scr_reg[13]) + 36'(scr_reg[7]));
        rv[7] = sat36(36'(scr_reg[14]) - 36'(scr_reg[6]));
        rv[8] = sat36(36'(scr_reg[11]) + 36'(c_reg));
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        init_next     = init_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        load_next     = load_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        vz_next       = vz_reg;
        c_next        = c_reg;
        s_next        = s_reg;
        c1_next       = c1_reg;
        scr_next      = scr_reg;
        coef_next     = coef_reg;
        cneg_next     = cneg_reg;
        mcol_next     = mcol_reg;
        iss_vld_next  = 1'b0;
        iss_ax_next   = iss_ax_reg;
        iss_neg_next  = iss_neg_reg;
        iss_row_next  = iss_row_reg;
        iss_term_next = iss_term_reg;
        iss_scr_next  = iss_scr_reg;
        acc_next      = acc_reg;
        sat_next      = sat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_sat_next    = m_sat_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = load_reg;
        mem_raddr     = idx_reg;
        mul_a         = '0;
        mul_b         = '0;
        trig_start    = 1'b0;

        contrib = iss_neg_reg ? -36'(mul_res.value) : 36'(mul_res.value);
        sum36   = acc_reg + contrib;
        wsum    = sat36(sum36);

        // retire the product issued last cycle
        if (iss_vld_reg) begin
            sat_next = sat_next | mul_res.sat;
            if (iss_ax_reg) begin
                scr_next[iss_scr_reg] = mul_res.value;
            end else if (iss_term_reg == 2'd3) begin
                mem_we    = 1'b1;
                mem_waddr = {col_reg, iss_row_reg};
                mem_wdata = wsum.value;
                sat_next  = sat_next | wsum.sat;
            end else begin
                acc_next = (iss_term_reg == 2'd0) ? contrib : sum36;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next  = s_req_type;
                    idx_next  = s_elem_index;
                    load_next = s_load_value;
                    vx_next   = s_op_x;
                    vy_next   = s_op_y;
                    vz_next   = s_op_z;
                    sat_next  = 1'b0;
                    cnt_next  = '0;
                    col_next  = '0;
                    case (s_req_type)
                        REQ_IDENTITY, REQ_ZERO: state_next = ST_CLEAR;
                        REQ_LOAD:               state_next = ST_LOAD;
                        REQ_TRANSLATE, REQ_SCALE: state_next = ST_COEF;
                        REQ_ROT_AXIS, REQ_ROT_X, REQ_ROT_Y, REQ_ROT_Z: begin
                            trig_start = 1'b1;
                            state_next = ST_TRIG;
                        end
                        REQ_READ: state_next = ST_RDOUT;
                        default:  state_next = ST_RDOUT;
                    endcase
                end
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = ((req_reg == REQ_IDENTITY || init_reg) &&
                             (cnt_reg inside {4'd0, 4'd5, 4'd10, 4'd15})) ? ONE : '0;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_RDOUT;
                end
            end
            ST_LOAD: begin
                mem_we     = 1'b1;
                state_next = ST_RDOUT;
            end
            ST_TRIG: begin
                if (trig_res.done) begin
                    c_next     = trig_res.cos_v;
                    s_next     = trig_res.sin_v;
                    c1_next    = ONE - trig_res.cos_v;
                    cnt_next   = '0;
                    state_next = (req_reg == REQ_ROT_AXIS) ? ST_AXPRE : ST_COEF;
                end
            end
            ST_AXPRE: begin
                case (cnt_reg)
                    4'd0:    begin mul_a = vx_reg;     mul_b = vx_reg; end
                    4'd1:    begin mul_a = vy_reg;     mul_b = vy_reg; end
                    4'd2:    begin mul_a = vz_reg;     mul_b = vz_reg; end
                    4'd3:    begin mul_a = vx_reg;     mul_b = vy_reg; end
                    4'd4:    begin mul_a = vx_reg;     mul_b = vz_reg; end
                    4'd5:    begin mul_a = vy_reg;     mul_b = vz_reg; end
                    4'd6:    begin mul_a = vx_reg;     mul_b = s_reg;  end
                    4'd7:    begin mul_a = vy_reg;     mul_b = s_reg;  end
                    4'd8:    begin mul_a = vz_reg;     mul_b = s_reg;  end
                    4'd9:    begin mul_a = scr_reg[0]; mul_b = c1_reg; end
                    4'd10:   begin mul_a = scr_reg[1]; mul_b = c1_reg; end
                    4'd11:   begin mul_a = scr_reg[2]; mul_b = c1_reg; end
                    4'd12:   begin mul_a = scr_reg[3]; mul_b = c1_reg; end
                    4'd13:   begin mul_a = scr_reg[4]; mul_b = c1_reg; end
                    4'd14:   begin mul_a = scr_reg[5]; mul_b = c1_reg; end
                    default: begin mul_a = '0;         mul_b = '0;     end
                endcase
                iss_vld_next = (cnt_reg != 4'd15);
                iss_ax_next  = 1'b1;
                iss_scr_next = cnt_reg;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: begin
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 4; j++) begin
                        coef_next[k][j] = '0;
                        cneg_next[k][j] = 1'b0;
                    end
                end
                case (req_reg)
                    REQ_TRANSLATE: begin
                        for (int k = 0; k < 3; k++) begin
                            coef_next[k][k] = ONE;
                        end
                        coef_next[0][3] = vx_reg;
                        coef_next[1][3] = vy_reg;
                        coef_next[2][3] = vz_reg;
                    end
                    REQ_SCALE: begin
                        coef_next[0][0] = vx_reg;
                        coef_next[1][1] = vy_reg;
                        coef_next[2][2] = vz_reg;
                    end
                    REQ_ROT_AXIS: begin
                        for (int k = 0; k < 3; k++) begin
                            for (int j = 0; j < 3; j++) begin
                                coef_next[k][j] = rv[3 * j + k].value;
                            end
                        end
                        for (int n = 0; n < 9; n++) begin
                            sat_next = sat_next | rv[n].sat;
                        end
                    end
                    REQ_ROT_X: begin
                        coef_next[0][0] = ONE;
                        coef_next[1][1] = c_reg;
                        coef_next[1][2] = s_reg;
                        cneg_next[1][2] = 1'b1;
                        coef_next[2][1] = s_reg;
                        coef_next[2][2] = c_reg;
                    end
                    REQ_ROT_Y: begin
                        coef_next[0][0] = c_reg;
                        coef_next[0][2] = s_reg;
                        coef_next[1][1] = ONE;
                        coef_next[2][0] = s_reg;
                        cneg_next[2][0] = 1'b1;
                        coef_next[2][2] = c_reg;
                    end
                    REQ_ROT_Z: begin
                        coef_next[0][0] = c_reg;
                        coef_next[0][1] = s_reg;
                        cneg_next[0][1] = 1'b1;
                        coef_next[1][0] = s_reg;
                        coef_next[1][1] = c_reg;
                        coef_next[2][2] = ONE;
                    end
                    default: begin
                        coef_next[0][0] = ONE;
                    end
                endcase
                cnt_next   = '0;
                col_next   = '0;
                state_next = ST_COLRD;
            end
            ST_COLRD: begin
                mem_raddr = {col_reg, cnt_reg[1:0]};
                if (cnt_reg != 4'd0) begin
                    mcol_next[2'(cnt_reg - 4'd1)] = mem_rdata;
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd4) begin
                    cnt_next   = '0;
                    state_next = ST_COLMAC;
                end
            end
            ST_COLMAC: begin
                mul_a         = coef_reg[cnt_reg[3:2]][cnt_reg[1:0]];
                mul_b         = mcol_reg[cnt_reg[1:0]];
                iss_vld_next  = (cnt_reg < 4'd12);
                iss_ax_next   = 1'b0;
                iss_neg_next  = cneg_reg[cnt_reg[3:2]][cnt_reg[1:0]];
                iss_row_next  = cnt_reg[3:2];
                iss_term_next = cnt_reg[1:0];
                cnt_next      = cnt_reg + 4'd1;
                if (cnt_reg == 4'd12) begin
                    cnt_next   = '0;
                    col_next   = col_reg + 2'd1;
                    state_next = (col_reg == 2'd3) ? ST_RDOUT : ST_COLRD;
                end
            end
            ST_RDOUT: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = mem_rdata;
                    m_sat_next   = sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            col_reg     <= '0;
            init_reg    <= 1'b1;
            iss_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            init_reg    <= init_next;
            iss_vld_reg <= iss_vld_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        load_reg     <= load_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        vz_reg       <= vz_next;
        c_reg        <= c_next;
        s_reg        <= s_next;
        c1_reg       <= c1_next;
        scr_reg      <= scr_next;
        coef_reg     <= coef_next;
        cneg_reg     <= cneg_next;
        mcol_reg     <= mcol_next;
        iss_ax_reg   <= iss_ax_next;
        iss_neg_reg  <= iss_neg_next;
        iss_row_reg  <= iss_row_next;
        iss_term_reg <= iss_term_next;
        iss_scr_reg  <= iss_scr_next;
        acc_reg      <= acc_next;
        sat_reg      <= sat_next;
        m_value_reg  <= m_value_next;
        m_sat_reg    <= m_sat_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_element_value = m_value_reg;
    assign m_saturated     = m_sat_reg;

endmodule

// ----- rtl/mxa_checker.sv -----
// ----------------------------------------------------------------------------
// mxa_checker
// Port-level checks for the transform accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix4_transform_accumulator_defines.svh"

module mxa_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [3:0]         s_req_type,
    input logic [3:0]         s_elem_index,
    input logic signed [31:0] s_load_value,
    input logic signed [31:0] s_op_x,
    input logic signed [31:0] s_op_y,
    input logic signed [31:0] s_op_z,
    input logic signed [31:0] s_angle_deg,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_element_value,
    input logic               m_saturated
);

    `MXA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_element_value) && $stable(m_saturated), "result item changed while stalled")

    // one item in flight: ready drops right after an accept
    `MXA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second item accepted while busy")

    // no result can appear the cycle after an accept
    `MXA_ASSERT_NEXT(a_min_latency, aclk, aresetn, s_valid && s_ready, !m_valid || $past(m_valid), "result appeared too early")

    // reset starts the clearing pass with no result pending
    `MXA_ASSERT_RST(a_reset_state, aclk, aresetn, !m_valid && !s_ready, "bad state after reset")

endmodule

bind matrix4_transform_accumulator mxa_checker u_mxa_checker (.*);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for matrix4_transform_accumulator
// Drives request items with random idling on both channels, keeps its own
// copy of the transform matrix and checks every returned element and flag.
// ----------------------------------------------------------------------------
module testbench;
    import mxa_pkg::*;

    localparam int FB = 16;
    localparam int STEPS = 16;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_req_type = '0;
    logic [3:0]         s_elem_index = '0;
    logic signed [31:0] s_load_value = '0;
    logic signed [31:0] s_op_x = '0;
    logic signed [31:0] s_op_y = '0;
    logic signed [31:0] s_op_z = '0;
    logic signed [31:0] s_angle_deg = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_element_value;
    logic               m_saturated;

    matrix4_transform_accumulator uut (.*);

    always #5 aclk = ~aclk;

    typedef struct {
        logic signed [31:0] value;
        logic               sat;
    } elem_result_t;

    elem_result_t expected_elems[$];
    longint       mtx[16];
    bit           step_sat;
    int           errors = 0;
    bit           calm = 1'b0;   // no idling on either side

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) begin
            step_sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            step_sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return sat32(asr(a * b + (64'sd1 <<< (FB - 1)), FB));
    endfunction

    function automatic longint atan_tab(input int i);
        longint t[24] = '{754974720, 445687602, 235489089, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115};
        return t[i];
    endfunction

    task automatic sin_cos(input longint ang, output longint cq, output longint sq);
        longint one, full, half, quarter, r, x, y, z, dx, dy;
        bit neg;
        one = 64'sd1 <<< FB;
        full = 360 * one;
        half = 180 * one;
        quarter = 90 * one;
        r = ((ang % full) + full) % full;
        neg = 1'b0;
        if (r >= half) r -= full;
        if (r > quarter) begin
            r -= half;
            neg = 1'b1;
        end else if (r < -quarter) begin
            r += half;
            neg = 1'b1;
        end
        z = r * (64'sd1 <<< (24 - FB));
        x = 652032874;
        y = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab(i);
            end else begin
                x += dx; y -= dy; z += atan_tab(i);
            end
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        cq = asr(x + (64'sd1 <<< (29 - FB)), 30 - FB);
        sq = asr(y + (64'sd1 <<< (29 - FB)), 30 - FB);
    endtask

    task automatic rotate_rows(input int p, input int q, input longint c, input longint s);
        longint mp, mq;
        for (int b = 0; b < 16; b += 4) begin
            mp = mtx[b + p];
            mq = mtx[b + q];
            mtx[b + p] = sat32(qmul(mp, c) - qmul(mq, s));
            mtx[b + q] = sat32(qmul(mp, s) + qmul(mq, c));
        end
    endtask

    task automatic rotate_axis(input longint c, input longint s,
                               input longint x, input longint y, input longint z);
        longint c1, xy, xz, yz, xs, ys, zs, m0, m1, m2;
        longint r[9];
        c1 = (64'sd1 <<< FB) - c;
        xy = qmul(qmul(x, y), c1);
        xz = qmul(qmul(x, z), c1);
        yz = qmul(qmul(y, z), c1);
        xs = qmul(x, s);
        ys = qmul(y, s);
        zs = qmul(z, s);
        r[0] = sat32(qmul(qmul(x, x), c1) + c);
        r[1] = sat32(xy + zs);
        r[2] = sat32(xz - ys);
        r[3] = sat32(xy - zs);
        r[4] = sat32(qmul(qmul(y, y), c1) + c);
        r[5] = sat32(yz + xs);
        r[6] = sat32(xz + ys);
        r[7] = sat32(yz - xs);
        r[8] = sat32(qmul(qmul(z, z), c1) + c);
        for (int b = 0; b < 16; b += 4) begin
            m0 = mtx[b];
            m1 = mtx[b + 1];
            m2 = mtx[b + 2];
            for (int k = 0; k < 3; k++)
                mtx[b + k] = sat32(qmul(r[k], m0) + qmul(r[3 + k], m1) + qmul(r[6 + k], m2));
        end
    endtask

    task automatic set_identity();
        for (int k = 0; k < 16; k++) mtx[k] = (k % 5 == 0) ? (64'sd1 <<< FB) : 0;
    endtask

    task automatic apply_request(input logic [3:0] req, input logic [3:0] idx,
                                 input logic signed [31:0] lv, input logic signed [31:0] ox,
                                 input logic signed [31:0] oy, input logic signed [31:0] oz,
                                 input logic signed [31:0] ang);
        longint v[3], c, s;
        elem_result_t res;
        v[0] = ox; v[1] = oy; v[2] = oz;
        step_sat = 1'b0;
        case (req)
            REQ_IDENTITY: set_identity();
            REQ_ZERO: for (int k = 0; k < 16; k++) mtx[k] = 0;
            REQ_LOAD: mtx[idx] = lv;
            REQ_TRANSLATE:
                for (int b = 0; b < 16; b += 4)
                    for (int k = 0; k < 3; k++)
                        mtx[b + k] = sat32(mtx[b + k] + qmul(mtx[b + 3], v[k]));
            REQ_SCALE:
                for (int b = 0; b < 16; b += 4)
                    for (int k = 0; k < 3; k++)
                        mtx[b + k] = qmul(mtx[b + k], v[k]);
            REQ_ROT_AXIS: begin
                sin_cos(ang, c, s);
                rotate_axis(c, s, v[0], v[1], v[2]);
            end
            REQ_ROT_X: begin
                sin_cos(ang, c, s);
                rotate_rows(1, 2, c, s);
            end
            REQ_ROT_Y: begin
                sin_cos(ang, c, s);
                rotate_rows(2, 0, c, s);
            end
            REQ_ROT_Z: begin
                sin_cos(ang, c, s);
                rotate_rows(0, 1, c, s);
            end
            default: ;
        endcase
        res.value = mtx[idx][31:0];
        res.sat = step_sat;
        expected_elems.push_back(res);
    endtask

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 32);
    endfunction

    task automatic send_item(input logic [3:0] req, input logic [3:0] idx,
                             input logic signed [31:0] lv, input logic signed [31:0] ox,
                             input logic signed [31:0] oy, input logic signed [31:0] oz,
                             input logic signed [31:0] ang);
        while (idle_now()) @(posedge aclk);
        s_valid <= 1'b1;
        s_req_type <= req;
        s_elem_index <= idx;
        s_load_value <= lv;
        s_op_x <= ox;
        s_op_y <= oy;
        s_op_z <= oz;
        s_angle_deg <= ang;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_request(req, idx, lv, ox, oy, oz, ang);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_elems.size() == 0) begin
                report("result with nothing expected");
            end else begin
                if (m_element_value !== expected_elems[0].value)
                    report($sformatf("element_value %h expected %h",
                                     m_element_value, expected_elems[0].value));
                if (m_saturated !== expected_elems[0].sat)
                    report($sformatf("saturated %b expected %b",
                                     m_saturated, expected_elems[0].sat));
                void'(expected_elems.pop_front());
            end
        end
        m_ready <= !idle_now();
    end

    function automatic logic signed [31:0] rnd_q(input int mag);
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2 * mag)) - mag;
            2: return ($urandom_range(1) ? 1 : -1) * ($signed($urandom_range(4)) <<< FB);
            default: return $signed($urandom_range(2 * mag)) - mag + (1 <<< FB);
        endcase
    endfunction

    function automatic logic signed [31:0] rnd_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(720)) - 360 <<< FB;
            default: return $signed($urandom_range(360 << 8)) - (180 << 8) <<< (FB - 8);
        endcase
    endfunction

    task automatic test_directed();
        send_item(REQ_READ, 4'd0, 0, 0, 0, 0, 0);
        send_item(REQ_LOAD, 4'd15, 32'sh7fff_ffff, 0, 0, 0, 0);
        send_item(REQ_LOAD, 4'd3, 32'sh8000_0000, 0, 0, 0, 0);
        send_item(REQ_TRANSLATE, 4'd12, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000, 0);
        send_item(REQ_SCALE, 4'd0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff, 0);
        send_item(REQ_IDENTITY, 4'd5, 0, 0, 0, 0, 0);
        send_item(REQ_ROT_X, 4'd6, 0, 0, 0, 0, 32'sd90 <<< FB);
        send_item(REQ_ROT_Y, 4'd8, 0, 0, 0, 0, -(32'sd180 <<< FB));
        send_item(REQ_ROT_Z, 4'd1, 0, 0, 0, 0, 32'sh7fff_ffff);
        send_item(REQ_ROT_Z, 4'd4, 0, 0, 0, 0, 32'sh8000_0000);
        send_item(REQ_ROT_X, 4'd9, 0, 0, 0, 0, 32'sd135 <<< FB);
        send_item(REQ_ROT_AXIS, 4'd2, 0, 32'sh0001_0000, 0, 0, 32'sd30 <<< FB);
        send_item(REQ_ROT_AXIS, 4'd10, 0, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sd45 <<< FB);
        send_item(REQ_ZERO, 4'd0, 0, 0, 0, 0, 0);
        for (int code = 10; code < 16; code++)
            send_item(code[3:0], 4'd0, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                      32'shffff_ffff, 32'shffff_ffff);
        send_item(REQ_IDENTITY, 4'd15, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int n);
        logic [3:0] req;
        for (int i = 0; i < n; i++) begin
            // mostly transforms on a sane matrix, now and then a reset of it
            case ($urandom_range(19))
                0: req = REQ_IDENTITY;
                1: req = REQ_ZERO;
                2, 3, 4: req = REQ_LOAD;
                5: req = 4'($urandom_range(15));
                default: req = 4'($urandom_range(REQ_TRANSLATE, REQ_ROT_Z));
            endcase
            send_item(req, 4'($urandom_range(15)), rnd_q(3 << FB), rnd_q(2 << FB),
                      rnd_q(2 << FB), rnd_q(2 << FB), rnd_angle());
            if (i == n / 2) begin
                // hold off until the block has drained
                while (expected_elems.size() != 0) @(posedge aclk);
            end
        end
    endtask

    task automatic test_no_idle(input int n);
        calm = 1'b1;
        test_random(n);
        calm = 1'b0;
    endtask

    initial begin
        set_identity();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(1200);
        test_no_idle(300);
        test_random(500);
        while (expected_elems.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
